// File: rtl/core/gb3_pkg.sv
// ----------------------------------------------------------------------------
// gb3_pkg
// Shared types and constants of the 3x3 binomial blur: pixel width, config
// register indexes and reset values, the job passed from front to back.
// ----------------------------------------------------------------------------
package gb3_pkg;

	localparam int PIX_W         = 8;
	localparam int MAX_WIDTH_DEF = 1024;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;
	localparam int FW_W       = 11;
	localparam int FH_W       = 12;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
	localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 12'd480;

	// job queue between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

	typedef logic [PIX_W-1:0] pix_t;

	// window indexed [row][column], row 0 oldest line, column 2 newest pixel
	typedef pix_t [2:0][2:0] gb3_win_t;

	typedef struct packed {
		gb3_win_t win;
		logic     top;
		logic     left;
		logic     last_row;
		logic     last_col;
	} gb3_job_t;

	typedef struct packed {
		logic [FIFO_CNT_W-1:0] count;
		logic                  full;
		logic                  empty;
	} gb3_fifo_stat_t;

	// which neighbourhood of a job the back end is working on
	typedef enum logic [1:0] {
		PH_MAIN   = 2'b00,
		PH_ROW    = 2'b01,
		PH_COL    = 2'b10,
		PH_CORNER = 2'b11
	} gb3_phase_t;

endpackage

// File: rtl/core/gb3_front.sv
// ----------------------------------------------------------------------------
// gb3_front
// Accepts pixels, tracks row and column, keeps both line stores and the 3x3
// window, and posts one job per pixel that gives results.
// ----------------------------------------------------------------------------
module gb3_front #(
	parameter int MAX_WIDTH = gb3_pkg::MAX_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  gb3_pkg::pix_t                  pixel_in,
	input  logic                           cfg_valid,
	input  logic [gb3_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gb3_pkg::CFG_DATA_W-1:0] cfg_data,
	input  gb3_pkg::gb3_fifo_stat_t        fifo_stat,
	output logic                           job_valid,
	output gb3_pkg::gb3_job_t              job
);
	import gb3_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = (CW + 1 > FW_W) ? CW + 1 : FW_W;

	logic [FW_W-1:0] frame_width_q;
	logic [FH_W-1:0] frame_height_q;
	logic [CW-1:0]   col_q;
	logic [FH_W-1:0] row_q;

	logic [WW-1:0]   w_raw;
	logic [WW-1:0]   w_eff;
	logic [FH_W-1:0] h_eff;
	logic            is_last_col;
	logic            is_last_row;
	logic            in_acc;
	logic            cfg_hit;

	pix_t     line_upper [MAX_WIDTH];
	pix_t     line_lower [MAX_WIDTH];
	pix_t     rd_upper_s1;
	pix_t     rd_lower_s1;
	pix_t     px_s1;
	logic [CW-1:0] col_s1;
	logic     v_s1;
	logic     emit_s1;
	logic     top_s1;
	logic     left_s1;
	logic     last_row_s1;
	logic     last_col_s1;

	gb3_win_t win_q;
	gb3_win_t win_next;
	pix_t     col_pix [3];

	// geometry, out-of-range values pulled into the usable range
	assign w_raw = WW'(frame_width_q);
	always_comb begin
		if (w_raw < WW'(2)) begin
			w_eff = WW'(2);
		end else if (w_raw > WW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = w_raw;
		end
	end
	assign h_eff = (frame_height_q < FH_W'(2)) ? FH_W'(2) : frame_height_q;

	assign is_last_col = (WW'(col_q) == (w_eff - WW'(1)));
	assign is_last_row = (row_q == (h_eff - FH_W'(1)));

	// room for the job of the pixel still in stage one
	assign in_ready = (fifo_stat.count + FIFO_CNT_W'(v_s1)) < FIFO_CNT_W'(FIFO_DEPTH);
	assign in_acc   = in_valid && in_ready;
	assign cfg_hit  = cfg_valid &&
		((cfg_index == REG_FRAME_WIDTH) || (cfg_index == REG_FRAME_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
			col_q          <= '0;
			row_q          <= '0;
			v_s1           <= 1'b0;
			win_q          <= '0;
		end else begin
			v_s1 <= in_acc;
			if (v_s1) begin
				win_q <= win_next;
			end
			if (cfg_hit) begin
				// a write to either register restarts the frame
				if (cfg_index == REG_FRAME_WIDTH) begin
					frame_width_q <= cfg_data[FW_W-1:0];
				end else begin
					frame_height_q <= cfg_data[FH_W-1:0];
				end
				col_q <= '0;
				row_q <= '0;
			end else if (in_acc) begin
				if (is_last_col) begin
					col_q <= '0;
					row_q <= is_last_row ? '0 : row_q + FH_W'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	// stage one payload and classification
	always_ff @(posedge clk) begin
		if (in_acc) begin
			px_s1       <= pixel_in;
			col_s1      <= col_q;
			emit_s1     <= (row_q != '0) && (col_q != '0);
			top_s1      <= (row_q == FH_W'(1));
			left_s1     <= (col_q == CW'(1));
			last_row_s1 <= is_last_row;
			last_col_s1 <= is_last_col;
		end
	end

	// line stores: read at accept, rotate in the cycle after
	always_ff @(posedge clk) begin
		if (in_acc) begin
			rd_upper_s1 <= line_upper[col_q];
			rd_lower_s1 <= line_lower[col_q];
		end
		if (v_s1) begin
			line_upper[col_s1] <= rd_lower_s1;
			line_lower[col_s1] <= px_s1;
		end
	end

	assign col_pix[0] = rd_upper_s1;
	assign col_pix[1] = rd_lower_s1;
	assign col_pix[2] = px_s1;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			win_next[k][0] = win_q[k][1];
			win_next[k][1] = win_q[k][2];
			win_next[k][2] = col_pix[k];
		end
	end

	assign job_valid    = v_s1 && emit_s1;
	assign job.win      = win_next;
	assign job.top      = top_s1;
	assign job.left     = left_s1;
	assign job.last_row = last_row_s1;
	assign job.last_col = last_col_s1;

endmodule

// File: rtl/core/gb3_fifo.sv
// ----------------------------------------------------------------------------
// gb3_fifo
// Short job queue between front and back so that each side stalls on its own.
// ----------------------------------------------------------------------------
module gb3_fifo (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  gb3_pkg::gb3_job_t       push_job,
	input  logic                    pop,
	output gb3_pkg::gb3_job_t       head_job,
	output gb3_pkg::gb3_fifo_stat_t stat
);
	import gb3_pkg::*;

	gb3_job_t              entry_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + FIFO_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - FIFO_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	assign head_job   = entry_q[rd_ptr_q];
	assign stat.count = count_q;
	assign stat.full  = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign stat.empty = (count_q == '0);

endmodule

// File: rtl/core/gb3_back.sv
// ----------------------------------------------------------------------------
// gb3_back
// Takes jobs from the queue, expands each into one to four neighbourhoods,
// applies the 1-2-1 kernel with rounding and registers the result.
// ----------------------------------------------------------------------------
module gb3_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_avail,
	input  gb3_pkg::gb3_job_t job,
	output logic              job_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output gb3_pkg::pix_t     pixel_out,
	output logic              frame_last
);
	import gb3_pkg::*;

	gb3_phase_t ph_q;
	gb3_phase_t ph_next;
	logic       ph_done;
	logic       out_valid_q;
	logic       load;
	logic       row_var;
	logic       col_var;
	logic [1:0] rsel [3];
	logic [1:0] csel [3];
	pix_t       m [3][3];
	logic [12:0] sum;
	logic [8:0]  val;

	assign load = job_avail && (!out_valid_q || out_ready);

	// next neighbourhood of this job, or done
	always_comb begin
		ph_next = PH_MAIN;
		ph_done = 1'b1;
		case (ph_q)
			PH_MAIN: begin
				if (job.last_row) begin
					ph_next = PH_ROW;
					ph_done = 1'b0;
				end else if (job.last_col) begin
					ph_next = PH_COL;
					ph_done = 1'b0;
				end
			end
			PH_ROW: begin
				if (job.last_col) begin
					ph_next = PH_COL;
					ph_done = 1'b0;
				end
			end
			PH_COL: begin
				if (job.last_row) begin
					ph_next = PH_CORNER;
					ph_done = 1'b0;
				end
			end
			default: begin
				ph_done = 1'b1;
			end
		endcase
	end

	// mirrored rows and columns for the border cases
	assign row_var = (ph_q == PH_ROW) || (ph_q == PH_CORNER);
	assign col_var = (ph_q == PH_COL) || (ph_q == PH_CORNER);

	assign rsel[0] = row_var ? 2'd1 : (job.top ? 2'd2 : 2'd0);
	assign rsel[1] = row_var ? 2'd2 : 2'd1;
	assign rsel[2] = row_var ? 2'd1 : 2'd2;
	assign csel[0] = col_var ? 2'd1 : (job.left ? 2'd2 : 2'd0);
	assign csel[1] = col_var ? 2'd2 : 2'd1;
	assign csel[2] = col_var ? 2'd1 : 2'd2;

	always_comb begin
		for (int y = 0; y < 3; y++) begin
			for (int x = 0; x < 3; x++) begin
				m[y][x] = job.win[rsel[y]][csel[x]];
			end
		end
	end

	assign sum = 13'(m[0][0]) + {4'd0, m[0][1], 1'b0} + 13'(m[0][2])
		+ {4'd0, m[1][0], 1'b0} + {3'd0, m[1][1], 2'b00} + {4'd0, m[1][2], 1'b0}
		+ 13'(m[2][0]) + {4'd0, m[2][1], 1'b0} + 13'(m[2][2]) + 13'd7;
	assign val = sum[12:4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q        <= PH_MAIN;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				ph_q        <= ph_done ? PH_MAIN : ph_next;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pixel_out  <= (val > 9'd255) ? 8'hFF : val[7:0];
			frame_last <= (ph_q == PH_CORNER);
		end
	end

	assign job_pop   = load && ph_done;
	assign out_valid = out_valid_q;

endmodule

// File: rtl/core/gaussian_blur_3x3.sv
// ----------------------------------------------------------------------------
// gaussian_blur_3x3
// Streaming 3x3 binomial blur of an 8-bit grey frame with mirrored borders.
//
//   channel   direction  handshake              payload
//   in        sink       in_valid / in_ready    pixel_in
//   out       source     out_valid / out_ready  pixel_out, frame_last
//   cfg       sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One pixel a cycle is taken while the job queue has room and each gives at
// most one result; the back end emits one result a cycle while out_ready
// allows, so a pixel on the last row or at the last column gives two results
// and one at the last column of the last row four. A result passes the line
// store read with pixel register, job queue write, kernel and output register.
// Reset clears counters, window and queue; line stores are not cleared.
// A four-entry job queue lets output stalls back up without losing pixels.
// ----------------------------------------------------------------------------
module gaussian_blur_3x3 #(
	parameter int MAX_WIDTH = gb3_pkg::MAX_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  gb3_pkg::pix_t                  pixel_in,
	output logic                           out_valid,
	input  logic                           out_ready,
	output gb3_pkg::pix_t                  pixel_out,
	output logic                           frame_last,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [gb3_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gb3_pkg::CFG_DATA_W-1:0] cfg_data
);
	import gb3_pkg::*;

	logic           job_push;
	logic           job_pop;
	gb3_job_t       front_job;
	gb3_job_t       head_job;
	gb3_fifo_stat_t fifo_stat;

	assign cfg_ready = 1'b1;

	gb3_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pixel_in  (pixel_in),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fifo_stat (fifo_stat),
		.job_valid (job_push),
		.job       (front_job)
	);

	gb3_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_job (front_job),
		.pop      (job_pop),
		.head_job (head_job),
		.stat     (fifo_stat)
	);

	gb3_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_avail  (!fifo_stat.empty),
		.job        (head_job),
		.job_pop    (job_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_out  (pixel_out),
		.frame_last (frame_last)
	);

`ifndef SYNTH
	// the credit check at the input must keep the queue from overflowing
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(job_push && fifo_stat.full) |-> job_pop)
		else $error("job queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> !fifo_stat.empty)
		else $error("job queue underflow");

	// a full queue must hold off new pixels
	a_full_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_stat.full |-> !in_ready)
		else $error("pixel request taken with full job queue");
`endif

endmodule
